[rtl/core/md5_pkg.sv]
// ---------------------------------------------------------------------------
// MD5 package
// Transfer types, chaining constants, round constants and per-round tables
// shared by the digest engine and its round unit.
// ---------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  // Input transfer: one optional message byte and an end mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } md5_in_t;

  // Output transfer: the 16-byte digest, byte 0 in digest_low[7:0]
  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } md5_out_t;

  // Working words of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_abcd_t;

  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hefcd_ab89;
  localparam logic [31:0] IV_C = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D = 32'h1032_5476;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_WORDS = BLOCK_BYTES / 4;
  localparam int unsigned ROUNDS      = 64;

  // Additive constant of each round
  function automatic logic [31:0] md5_k(input logic [5:0] rnd);
    logic [31:0] k;
    unique case (rnd)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left-rotate amount, chosen by phase and the low two round bits
  function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each round
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = r;
      2'd1: g = {r[1:0], 2'b00} + r + 4'd1;
      2'd2: g = {r[2:0], 1'b0} + r + 4'd5;
      2'd3: g = {r[0], 3'b000} - r;
      default: g = r;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/core/md5_round.sv]
// ---------------------------------------------------------------------------
// MD5 round unit
// One compression round: mixing function, four-term add, rotate, add.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_round import md5_pkg::*; (
  input  md5_abcd_t   cur_i,
  input  logic [31:0] word_i,
  input  logic [5:0]  rnd_i,
  output md5_abcd_t   nxt_o
);

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_dbl;

  always_comb begin
    unique case (rnd_i[5:4])
      2'd0: f = (cur_i.b & cur_i.c) | (~cur_i.b & cur_i.d);
      2'd1: f = (cur_i.b & cur_i.d) | (cur_i.c & ~cur_i.d);
      2'd2: f = cur_i.b ^ cur_i.c ^ cur_i.d;
      2'd3: f = cur_i.c ^ (cur_i.b | ~cur_i.d);
      default: f = '0;
    endcase
  end

  assign t       = cur_i.a + f + word_i + md5_k(rnd_i);
  assign rot_dbl = {t, t} << md5_rot(rnd_i);

  // Shift the words along; only b takes new arithmetic
  assign nxt_o.a = cur_i.d;
  assign nxt_o.d = cur_i.c;
  assign nxt_o.c = cur_i.b;
  assign nxt_o.b = cur_i.b + rot_dbl[63:32];

endmodule

`default_nettype wire

[rtl/core/md5_message_digest_top.sv]
// ---------------------------------------------------------------------------
// MD5 message digest engine
// Collects message bytes into a 64-byte block, compresses each full block
// with one shared round unit, pads at the end mark and returns the digest.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | to block  | in_valid_i / in_stall_o | md5_in_t  (byte, marks)
//  out     | from block| out_valid_o/out_stall_i | md5_out_t (digest halves)
//
//  A plain byte transfer leaves the engine idle. A byte that completes the
//  block starts 64 rounds through the single round unit, then a fold of
//  the result into the chaining words. An end mark adds a padding sweep
//  of one block byte per cycle from the fill position to the block end
//  and one more compression; with 56 or more bytes filled a second full
//  sweep and compression follow. The input stalls throughout that work.
//  Reset loads the initial chaining words and clears the bit count; the
//  block store needs no clearing since padding writes every byte it reads.
//  A digest held against out_stall_i keeps the engine in its final step.
// ---------------------------------------------------------------------------
`default_nettype none

module md5_message_digest_top import md5_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output md5_out_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FINAL,
    S_PAD
  } state_e;

  // What follows the fold of a compression
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_OUT
  } after_e;

  state_e      state_q;
  after_e      after_q;
  logic [31:0] chain_q [4];
  logic [63:0] count_q;
  md5_abcd_t   work_q;
  md5_abcd_t   work_nxt;
  logic [5:0]  rnd_q;
  logic [5:0]  pad_idx_q;
  logic        mark_q;
  logic        len_q;
  logic        out_valid_q;
  md5_out_t    out_q;

  // Block store: sixteen little-endian words, byte-addressed on write
  logic [3:0][7:0] blk_q [BLOCK_WORDS];
  logic            wr_en;
  logic [5:0]      wr_idx;
  logic [7:0]      wr_byte;

  logic       accept;
  logic [5:0] pos;
  logic [5:0] pos_nxt;
  logic [5:0] pos_after;
  logic [7:0] pad_byte;
  logic       out_free;
  logic       out_load;
  logic [31:0] sum [4];

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign pos       = count_q[8:3];
  assign pos_nxt   = pos + 6'd1;
  assign pos_after = in_data_i.byte_valid ? pos_nxt : pos;
  assign out_free  = !(out_valid_q && out_stall_i);
  assign out_load  = (state_q == S_FINAL) && (after_q == AFT_OUT) && out_free;

  // Mark byte first, then zeros; the last eight bytes hold the bit count when the sweep carries it
  always_comb begin
    priority if (mark_q) begin
      pad_byte = PAD_MARK;
    end else if (len_q && (pad_idx_q >= LEN_POS)) begin
      pad_byte = count_q[{pad_idx_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pad_idx_q;
    wr_byte = pad_byte;
    if (accept && in_data_i.byte_valid) begin
      wr_en   = 1'b1;
      wr_idx  = pos;
      wr_byte = in_data_i.data_byte;
    end else if (state_q == S_PAD) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blk_q[wr_idx[5:2]][wr_idx[1:0]] <= wr_byte;
    end
  end

  md5_round u_round (
    .cur_i  (work_q),
    .word_i (blk_q[md5_msg_idx(rnd_q)]),
    .rnd_i  (rnd_q),
    .nxt_o  (work_nxt)
  );

  assign sum[0] = chain_q[0] + work_q.a;
  assign sum[1] = chain_q[1] + work_q.b;
  assign sum[2] = chain_q[2] + work_q.c;
  assign sum[3] = chain_q[3] + work_q.d;

  // Working words and digest payload: no reset needed; hold the working
  // words through the final step so a stalled digest keeps its sum
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      work_q <= work_nxt;
    end else if (state_q != S_FINAL) begin
      work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3]};
    end
    if (out_load) begin
      out_q.digest_low  <= {sum[1], sum[0]};
      out_q.digest_high <= {sum[3], sum[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      after_q     <= AFT_IDLE;
      chain_q[0]  <= IV_A;
      chain_q[1]  <= IV_B;
      chain_q[2]  <= IV_C;
      chain_q[3]  <= IV_D;
      count_q     <= '0;
      rnd_q       <= '0;
      pad_idx_q   <= '0;
      mark_q      <= 1'b0;
      len_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the digest once taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.byte_valid) begin
              count_q <= count_q + 64'd8;
            end
            priority if (in_data_i.byte_valid && pos_nxt == '0) begin
              // block full: compress, then pad from the start if marked
              state_q   <= S_ROUND;
              rnd_q     <= '0;
              after_q   <= in_data_i.end_of_message ? AFT_PAD : AFT_IDLE;
              pad_idx_q <= '0;
              mark_q    <= 1'b1;
              len_q     <= 1'b1;
            end else if (in_data_i.end_of_message) begin
              state_q   <= S_PAD;
              pad_idx_q <= pos_after;
              mark_q    <= 1'b1;
              len_q     <= (pos_after < LEN_POS);
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          mark_q    <= 1'b0;
          pad_idx_q <= pad_idx_q + 6'd1;
          if (&pad_idx_q) begin
            // sweep done: compress; a sweep without the length needs another
            state_q   <= S_ROUND;
            rnd_q     <= '0;
            after_q   <= len_q ? AFT_OUT : AFT_PAD;
            pad_idx_q <= '0;
            len_q     <= 1'b1;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (&rnd_q) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          unique case (after_q)
            AFT_IDLE: begin
              chain_q <= sum;
              state_q <= S_IDLE;
            end
            AFT_PAD: begin
              chain_q <= sum;
              state_q <= S_PAD;
            end
            AFT_OUT: begin
              // hold until the output register is free, then restart
              if (out_free) begin
                out_valid_q <= 1'b1;
                chain_q[0]  <= IV_A;
                chain_q[1]  <= IV_B;
                chain_q[2]  <= IV_C;
                chain_q[3]  <= IV_D;
                count_q     <= '0;
                state_q     <= S_IDLE;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
